// File: src/mtke_pkg.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry package
// Shared types, action codes, key codes and character tables.
// ----------------------------------------------------------------------------
package mtke_pkg;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_APPEND  = 3'd1;
    localparam logic [2:0] ACT_REPLACE = 3'd2;
    localparam logic [2:0] ACT_DELETE  = 3'd3;
    localparam logic [2:0] ACT_SAVE    = 3'd4;
    localparam logic [2:0] ACT_CANCEL  = 3'd5;

    localparam logic [7:0] KEY_HASH   = 8'h23;
    localparam logic [7:0] KEY_STAR   = 8'h2A;
    localparam logic [7:0] KEY_A      = 8'h41;
    localparam logic [7:0] KEY_B      = 8'h42;
    localparam logic [7:0] KEY_C      = 8'h43;
    localparam logic [7:0] KEY_D      = 8'h44;
    localparam logic [7:0] KEY_ONE    = 8'h31;
    localparam logic [7:0] KEY_NINE   = 8'h39;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_A_LOWER = 8'h61;
    localparam logic [7:0] CHAR_Z_LOWER = 8'h7A;
    localparam logic [7:0] CHAR_CASE    = 8'h20;
    localparam logic [7:0] LEN_MAX      = 8'hFF;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0]  MAX_LENGTH_RESET = 8'd99;

    localparam logic CFG_REPEAT_TIMEOUT = 1'b0;
    localparam logic CFG_MAX_LENGTH     = 1'b1;

    typedef struct packed {
        logic        op;
        logic [7:0]  key_code;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] char_out;
        logic [7:0] text_len;
    } result_t;

    typedef struct packed {
        logic [15:0] repeat_timeout_ms;
        logic [7:0]  max_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  last_key;
        logic [31:0] last_time;
        logic [1:0]  press_idx;
        logic        upper;
        logic        punct;
        logic [7:0]  length;
    } state_t;

    function automatic logic [7:0] letter_char(input logic [3:0] digit,
                                               input logic [1:0] idx);
        logic [7:0] ch;
        if (digit == 4'd9) begin
            unique case (idx)
                2'd0:    ch = 8'h79;
                2'd1:    ch = 8'h7A;
                default: ch = 8'h30;
            endcase
        end else begin
            ch = 8'(CHAR_A_LOWER + 8'(digit) * 8'd3 - 8'd3 + 8'(idx));
        end
        return ch;
    endfunction

    function automatic logic [7:0] punct_char(input logic [3:0] digit);
        logic [7:0] ch;
        unique case (digit)
            4'd1:    ch = 8'h2E;
            4'd2:    ch = 8'h2C;
            4'd3:    ch = 8'h21;
            4'd4:    ch = 8'h3F;
            4'd5:    ch = 8'h2D;
            4'd6:    ch = 8'h2B;
            4'd7:    ch = 8'h3D;
            4'd8:    ch = 8'h2F;
            default: ch = 8'h26;
        endcase
        return ch;
    endfunction

endpackage

// File: src/mtke_if.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry channels
// Valid/ready channels for key events, edit results and register writes.
// ----------------------------------------------------------------------------
interface mtke_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  key_code;
    logic [31:0] now_ms;

    modport source (output valid, op, key_code, now_ms, input ready);
    modport sink (input valid, op, key_code, now_ms, output ready);
endinterface

interface mtke_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] char_out;
    logic [7:0] text_len;

    modport source (output valid, action, char_out, text_len, input ready);
    modport sink (input valid, action, char_out, text_len, output ready);
endinterface

interface mtke_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/mtke_cfg_regs.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry configuration registers
// Holds the repeat timeout and the length limit, written by index.
// ----------------------------------------------------------------------------
module mtke_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic              wr_index,
    input  logic [15:0]       wr_data,
    output mtke_pkg::cfg_t    cfg
);
    import mtke_pkg::*;

    logic [15:0] timeout_reg;
    logic [7:0]  max_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            max_len_reg <= MAX_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_REPEAT_TIMEOUT: timeout_reg <= wr_data;
                default:            max_len_reg <= wr_data[7:0];
            endcase
        end
    end

    assign cfg.repeat_timeout_ms = timeout_reg;
    assign cfg.max_length        = max_len_reg;

endmodule

// File: src/mtke_decode.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry decoder
// Turns one key event and the current entry state into an edit command
// and the next entry state.
// ----------------------------------------------------------------------------
module mtke_decode (
    input  mtke_pkg::item_t   item,
    input  mtke_pkg::state_t  st,
    input  mtke_pkg::cfg_t    cfg,
    output mtke_pkg::result_t res,
    output mtke_pkg::state_t  st_next
);
    import mtke_pkg::*;

    logic        can_append;
    logic        is_digit;
    logic [31:0] age;
    logic        is_repeat;
    logic [1:0]  idx;
    logic [7:0]  letter;
    logic [7:0]  len_inc;
    logic [7:0]  len_dec;

    assign can_append = (st.length < cfg.max_length) && (st.length != LEN_MAX);
    assign is_digit   = (item.key_code >= KEY_ONE) && (item.key_code <= KEY_NINE);
    assign age        = item.now_ms - st.last_time;
    assign is_repeat  = (item.key_code == st.last_key)
                        && (age <= {16'd0, cfg.repeat_timeout_ms})
                        && (st.length != 8'd0);
    assign idx        = is_repeat ? ((st.press_idx >= 2'd2) ? 2'd0 : 2'(st.press_idx + 2'd1))
                                  : 2'd0;
    assign len_inc    = 8'(st.length + 8'd1);
    assign len_dec    = 8'(st.length - 8'd1);

    always_comb
    begin
        letter = letter_char(item.key_code[3:0], idx);
        if (st.upper && (letter >= CHAR_A_LOWER) && (letter <= CHAR_Z_LOWER))
        begin
            letter = 8'(letter - CHAR_CASE);
        end
    end

    always_comb
    begin
        st_next      = st;
        res.action   = ACT_NONE;
        res.char_out = 8'd0;

        if (item.op || (item.key_code == KEY_HASH))
        begin
            st_next.last_key = 8'd0;
            res.action       = ACT_SAVE;
        end
        else if (item.key_code == KEY_D)
        begin
            st_next.last_key = 8'd0;
            res.action       = ACT_CANCEL;
        end
        else if (item.key_code == KEY_A)
        begin
            if (st.length != 8'd0)
            begin
                st_next.length   = len_dec;
                st_next.last_key = 8'd0;
                res.action       = ACT_DELETE;
            end
        end
        else if (item.key_code == KEY_B)
        begin
            st_next.upper = !st.upper;
            st_next.punct = 1'b0;
        end
        else if (item.key_code == KEY_C)
        begin
            st_next.punct = !st.punct;
            st_next.upper = 1'b0;
        end
        else if (item.key_code == KEY_STAR)
        begin
            if (can_append)
            begin
                st_next.length   = len_inc;
                st_next.last_key = 8'd0;
                res.action       = ACT_APPEND;
                res.char_out     = CHAR_SPACE;
            end
        end
        else if (is_digit)
        begin
            if (st.punct)
            begin
                if (can_append)
                begin
                    st_next.length   = len_inc;
                    st_next.last_key = 8'd0;
                    res.action       = ACT_APPEND;
                    res.char_out     = punct_char(item.key_code[3:0]);
                end
            end
            else if (is_repeat || can_append)
            begin
                st_next.press_idx = idx;
                st_next.last_key  = item.key_code;
                st_next.last_time = item.now_ms;
                res.char_out      = letter;
                if (is_repeat)
                begin
                    res.action = ACT_REPLACE;
                end
                else
                begin
                    st_next.length = len_inc;
                    res.action     = ACT_APPEND;
                end
            end
        end

        res.text_len = st_next.length;
    end

endmodule

// File: src/multitap_keypad_text_entry.sv
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry
// Turns timestamped keypad events into append, replace, delete, save and
// cancel commands for a text buffer, tracking the text length.
// ----------------------------------------------------------------------------
//  Channel      Dir   Payload                         Transfer
//  item_in      in    op, key_code, now_ms            valid & ready
//  result_out   out   action, char_out, text_len      valid & ready
//  cfg          in    index, data                     valid & ready
//
//  Each event yields one result: it is first held in the input register, then
//  passes through the decoder into the result register.
//  One event per cycle is sustained while results are taken; the decoder and state update set that.
//  A stalled result register holds the input register, which then drops ready.
//  Reset clears the entry state and loads the register defaults.
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry (
    input  logic         clk,
    input  logic         rst_n,
    mtke_in_if.sink      item_in,
    mtke_out_if.source   result_out,
    mtke_cfg_if.sink     cfg
);
    import mtke_pkg::*;

    cfg_t    cfg_val;
    item_t   item_reg;
    item_t   item_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    state_t  state_reg;
    state_t  state_next;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    in_xfer;

    assign cfg.ready = 1'b1;

    mtke_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    mtke_decode u_decode (
        .item    (item_reg),
        .st      (state_reg),
        .cfg     (cfg_val),
        .res     (res_next),
        .st_next (state_next)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready = !in_valid_reg || advance;
    assign in_xfer       = item_in.valid && item_in.ready;

    assign item_next.op       = item_in.op;
    assign item_next.key_code = item_in.key_code;
    assign item_next.now_ms   = item_in.now_ms;

    assign in_valid_next  = in_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_out.valid    = out_valid_reg;
    assign result_out.action   = res_reg.action;
    assign result_out.char_out = res_reg.char_out;
    assign result_out.text_len = res_reg.text_len;

`ifndef ASSERT_OFF
    a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.upper && state_reg.punct))
        else $error("upper case and punctuation modes both active");

    a_char_matches_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((res_reg.action == ACT_APPEND || res_reg.action == ACT_REPLACE)
                           == (res_reg.char_out != 8'd0)))
        else $error("character does not match the edit command");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.action == ACT_APPEND)
        |=> (state_reg.length == 8'($past(state_reg.length) + 8'd1)))
        else $error("append did not grow the text length by one");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("entry state changed without a decoded event");

    a_len_reported: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (res_reg.text_len == state_reg.length))
        else $error("reported length differs from the stored length");
`endif

endmodule
